// ----- hw/rtl/flru_pkg.sv -----
// Shared constants, types and state codes of the four-way LRU cache tag controller.
`default_nettype none

package flru_pkg;

    localparam int SET_COUNT  = 256;
    localparam int WAY_COUNT  = 4;
    localparam int TAG_BITS   = 24;
    localparam int STAMP_BITS = 32;
    localparam int ADDR_BITS  = 32;
    localparam int CNT_BITS   = 32;
    localparam int SET_BITS   = $clog2(SET_COUNT);
    localparam int WAY_BITS   = $clog2(WAY_COUNT);

    // One way of a set as kept in the tag RAM.
    typedef struct packed {
        logic                  valid;
        logic                  dirty;
        logic [TAG_BITS-1:0]   tag;
        logic [STAMP_BITS-1:0] stamp;
        logic [ADDR_BITS-1:0]  address;
    } way_t;

    // One RAM row holds every way of a set.
    typedef way_t [WAY_COUNT-1:0] row_t;

    // Lookup decision for one access.
    typedef struct packed {
        logic                 hit;
        logic [WAY_BITS-1:0]  way;
        logic                 evict;
        logic                 evict_dirty;
        logic [ADDR_BITS-1:0] evict_address;
    } lookup_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/flru_row_ram.sv -----
// Tag RAM: one row per set, one write port and one registered read port.
`default_nettype none

module flru_row_ram (
    input  wire logic                          clk,
    input  wire logic                          rd_en,
    input  wire logic [flru_pkg::SET_BITS-1:0] rd_addr,
    output flru_pkg::row_t                     rd_data,
    input  wire logic                          wr_en,
    input  wire logic [flru_pkg::SET_BITS-1:0] wr_addr,
    input  wire flru_pkg::row_t                wr_data
);

    flru_pkg::row_t mem [flru_pkg::SET_COUNT];
    flru_pkg::row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/flru_select.sv -----
// Hit search and victim choice over the ways of one set row.
`default_nettype none

module flru_select (
    input  wire flru_pkg::row_t                row,
    input  wire logic [flru_pkg::TAG_BITS-1:0] tag,
    output flru_pkg::lookup_t                  result
);

    logic                            hit_found;
    logic [flru_pkg::WAY_BITS-1:0]   hit_way;
    logic                            free_found;
    logic [flru_pkg::WAY_BITS-1:0]   free_way;
    logic [flru_pkg::WAY_BITS-1:0]   old_way;
    logic [flru_pkg::STAMP_BITS-1:0] old_stamp;
    logic [flru_pkg::WAY_BITS-1:0]   victim;

    always_comb
    begin
        hit_found  = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        for (int w = 0; w < flru_pkg::WAY_COUNT; w++)
        begin
            if (!hit_found && row[w].valid && (row[w].tag == tag))
            begin
                hit_found = 1'b1;
                hit_way   = flru_pkg::WAY_BITS'(w);
            end
            if (!free_found && !row[w].valid)
            begin
                free_found = 1'b1;
                free_way   = flru_pkg::WAY_BITS'(w);
            end
        end
    end

    // Oldest stamp; strict compare keeps the lowest way on a tie.
    always_comb
    begin
        old_way   = '0;
        old_stamp = row[0].stamp;
        for (int w = 1; w < flru_pkg::WAY_COUNT; w++)
        begin
            if (row[w].stamp < old_stamp)
            begin
                old_stamp = row[w].stamp;
                old_way   = flru_pkg::WAY_BITS'(w);
            end
        end
    end

    assign victim = free_found ? free_way : old_way;

    always_comb
    begin
        result.hit           = hit_found;
        result.way           = hit_found ? hit_way : victim;
        result.evict         = !hit_found && !free_found;
        result.evict_dirty   = result.evict ? row[old_way].dirty : 1'b0;
        result.evict_address = result.evict ? row[old_way].address : '0;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/four_way_lru_cache_tag_controller.sv -----
// Top level of the four-way LRU cache tag controller.
//
//   channel | handshake          | word
//   --------+--------------------+-----------------------------------------------
//   in      | in_valid/in_stall  | operation, set_index, tag, address, time_stamp
//   out     | out_valid/out_stall| hit, way_used, evicted, evicted_dirty,
//           |                    | evicted_address, hit_count, miss_count,
//           |                    | access_count
//
// An access reads the set row from the tag RAM in IDLE (registered read port),
// then does hit/victim selection, write-back and result load in LOOKUP. A new
// word is taken only in IDLE, so the next word waits for the current access.
// After reset a clearing pass writes every row (SET_COUNT = 256 rows) with
// in_stall high. A result held by out_stall holds the access in LOOKUP;
// the next input word can be taken in the cycle after the result loads.
`default_nettype none

module four_way_lru_cache_tag_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [7:0]  set_index,
    input  wire logic [23:0] tag,
    input  wire logic [31:0] address,
    input  wire logic [31:0] time_stamp,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             hit,
    output logic [1:0]       way_used,
    output logic             evicted,
    output logic             evicted_dirty,
    output logic [31:0]      evicted_address,
    output logic [31:0]      hit_count,
    output logic [31:0]      miss_count,
    output logic [31:0]      access_count
);

    localparam logic [flru_pkg::CNT_BITS-1:0] CNT_MAX = '1;

    flru_pkg::state_t state_reg, state_next;

    // clearing pass row counter
    logic [flru_pkg::SET_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic                          clr_last;

    // accepted word, held through the lookup
    logic                            req_write_reg;
    logic [flru_pkg::SET_BITS-1:0]   req_set_reg;
    logic [flru_pkg::TAG_BITS-1:0]   req_tag_reg;
    logic [flru_pkg::ADDR_BITS-1:0]  req_addr_reg;
    logic [flru_pkg::STAMP_BITS-1:0] req_stamp_reg;

    logic in_take;
    logic done;

    // RAM port signals
    logic                          rd_en;
    flru_pkg::row_t                rd_row;
    logic                          wr_en;
    logic [flru_pkg::SET_BITS-1:0] wr_addr;
    flru_pkg::row_t                wr_row;
    flru_pkg::row_t                upd_row;

    flru_pkg::lookup_t look;

    // result register and counters
    logic                           out_valid_reg, out_valid_next;
    flru_pkg::lookup_t              res_reg;
    logic [flru_pkg::CNT_BITS-1:0]  hits_reg, hits_next;
    logic [flru_pkg::CNT_BITS-1:0]  misses_reg, misses_next;
    logic [flru_pkg::CNT_BITS-1:0]  accesses_reg, accesses_next;

    flru_row_ram u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (set_index[flru_pkg::SET_BITS-1:0]),
        .rd_data (rd_row),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_row)
    );

    flru_select u_select (
        .row    (rd_row),
        .tag    (req_tag_reg),
        .result (look)
    );

    assign clr_last = (clr_cnt_reg == flru_pkg::SET_BITS'(flru_pkg::SET_COUNT - 1));
    assign in_take  = (state_reg == flru_pkg::ST_IDLE) && in_valid;
    // lookup finishes once the result register is free or being drained
    assign done     = (state_reg == flru_pkg::ST_LOOKUP) && (!out_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            flru_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = flru_pkg::ST_IDLE;
                end
            end
            flru_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = flru_pkg::ST_LOOKUP;
                end
            end
            flru_pkg::ST_LOOKUP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = flru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = flru_pkg::ST_CLEAR;
            end
        endcase
    end

    // row update for the write-back: refresh on a hit, fill on a miss
    always_comb
    begin
        upd_row = rd_row;
        if (look.hit)
        begin
            upd_row[look.way].stamp = req_stamp_reg;
            if (req_write_reg)
            begin
                upd_row[look.way].dirty = 1'b1;
            end
        end
        else
        begin
            upd_row[look.way].valid   = 1'b1;
            upd_row[look.way].dirty   = req_write_reg;
            upd_row[look.way].tag     = req_tag_reg;
            upd_row[look.way].stamp   = req_stamp_reg;
            upd_row[look.way].address = req_addr_reg;
        end
    end

    // state outputs
    always_comb
    begin
        in_stall     = 1'b1;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = req_set_reg;
        wr_row       = upd_row;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            flru_pkg::ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_row       = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            flru_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                rd_en    = in_valid;
            end
            flru_pkg::ST_LOOKUP:
            begin
                wr_en = done;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // counters and result flag
    always_comb
    begin
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        accesses_next  = accesses_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (done)
        begin
            out_valid_next = 1'b1;
            if (accesses_reg != CNT_MAX)
            begin
                accesses_next = accesses_reg + 1'b1;
            end
            if (look.hit)
            begin
                if (hits_reg != CNT_MAX)
                begin
                    hits_next = hits_reg + 1'b1;
                end
            end
            else if (misses_reg != CNT_MAX)
            begin
                misses_next = misses_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= flru_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            accesses_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            accesses_reg  <= accesses_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_write_reg <= operation;
            req_set_reg   <= set_index[flru_pkg::SET_BITS-1:0];
            req_tag_reg   <= tag[flru_pkg::TAG_BITS-1:0];
            req_addr_reg  <= address[flru_pkg::ADDR_BITS-1:0];
            req_stamp_reg <= time_stamp[flru_pkg::STAMP_BITS-1:0];
        end
        if (done)
        begin
            res_reg <= look;
        end
    end

    // counters only move when a new result loads, so they drive the port directly
    assign out_valid       = out_valid_reg;
    assign hit             = res_reg.hit;
    assign way_used        = res_reg.way;
    assign evicted         = res_reg.evict;
    assign evicted_dirty   = res_reg.evict_dirty;
    assign evicted_address = res_reg.evict_address;
    assign hit_count       = hits_reg;
    assign miss_count      = misses_reg;
    assign access_count    = accesses_reg;

endmodule

`default_nettype wire
